// ----- hw/rtl/xml_content_end_finder_defines.svh -----
// Assertion macros used by the checker file of the content end finder.
`ifndef XML_CONTENT_END_FINDER_DEFINES_SVH
`define XML_CONTENT_END_FINDER_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is high.
`define XCEF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define XCEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/xcef_pkg.sv -----
`default_nettype none

package xcef_pkg;

   // Default limit on element nesting.
   localparam int unsigned MaxDepthDefault = 255;

   // Queue between the classifier and the scanner.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   // Position and offset width.
   localparam int unsigned PosW = 32;

   // Character codes of interest.
   localparam logic [7:0] ChLt    = 8'h3C;
   localparam logic [7:0] ChGt    = 8'h3E;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChColon = 8'h3A;

   // Character classes: LETTER is a valid first name byte, NAMECH is a digit or colon.
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_LT,
      CLS_SLASH,
      CLS_GT,
      CLS_SPACE,
      CLS_LETTER,
      CLS_NAMECH
   } char_class_type;

   // One classified beat as it travels through the queue.
   typedef struct packed {
      char_class_type cls;
      logic           eot;
   } beat_type;

   // Scanner phases.
   typedef enum logic [2:0] {
      PH_CONTENT,
      PH_AFTER_LT,
      PH_NAME,
      PH_ATTR,
      PH_SKIP_CLOSE
   } phase_type;

   // Result codes.
   typedef enum logic [1:0] {
      OUT_FOUND     = 2'd0,
      OUT_NOT_FOUND = 2'd1,
      OUT_OVERFLOW  = 2'd2
   } outcome_type;

endpackage

`default_nettype wire

// ----- hw/rtl/xml_content_end_finder.sv -----
// An accepted byte is stored in the queue, scanned at the queue head, and its result is held in the result register.
// Throughput: one byte per cycle, set by the single-step scanner behind a four-beat queue.
// The scanner stalls only while a result waits on rsp and the queue then fills.
// Reset (synchronous, active high) empties the queue, clears the scan state and the result valid flag,
// and sets start_offset to 0.
`default_nettype none

module xml_content_end_finder #(
   parameter int unsigned MAX_DEPTH = xcef_pkg::MaxDepthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Input beats.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] text_byte
   input  wire logic         req_tlast,   // end_of_text
   // Result beats.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata,   // [1:0] outcome, [33:2] end_position, rest zero
   // Start offset register.
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata
);

   logic [xcef_pkg::PosW-1:0]   start_offset_ff;
   xcef_pkg::beat_type          push_beat, head_beat;
   logic                        push_valid, q_full, head_valid, pop;
   xcef_pkg::outcome_type       out_outcome;
   logic [xcef_pkg::PosW-1:0]   out_position;

   // Start offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= '0;
      end else if (csr_we) begin
         start_offset_ff <= csr_wdata;
      end
   end

   assign req_tready = !q_full;

   xcef_front u_front (
      .req_valid  (req_tvalid),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .push_beat  (push_beat),
      .push_valid (push_valid)
   );

   xcef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_beat  (push_beat),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_beat  (head_beat)
   );

   xcef_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .start_offset (start_offset_ff),
      .head_valid   (head_valid),
      .head_beat    (head_beat),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_outcome  (out_outcome),
      .out_position (out_position)
   );

   // Pack the result beat.
   assign rsp_tdata = {6'b000000, out_position, out_outcome};

endmodule

`default_nettype wire

// ----- hw/rtl/xcef_front.sv -----
`default_nettype none

module xcef_front (
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_byte,
   input  wire logic              req_last,
   output xcef_pkg::beat_type     push_beat,
   output logic                   push_valid
);

   // Sort each incoming byte into the class that the scanner acts on.
   always_comb begin
      push_beat.eot = req_last;
      push_valid    = req_valid;
      if (req_byte == xcef_pkg::ChLt) begin
         push_beat.cls = xcef_pkg::CLS_LT;
      end else if (req_byte == xcef_pkg::ChGt) begin
         push_beat.cls = xcef_pkg::CLS_GT;
      end else if (req_byte == xcef_pkg::ChSlash) begin
         push_beat.cls = xcef_pkg::CLS_SLASH;
      end else if (req_byte == xcef_pkg::ChSpace) begin
         push_beat.cls = xcef_pkg::CLS_SPACE;
      end else if ((req_byte >= 8'h41 && req_byte <= 8'h5A) ||
                   (req_byte >= 8'h61 && req_byte <= 8'h7A)) begin
         push_beat.cls = xcef_pkg::CLS_LETTER;
      end else if ((req_byte >= 8'h30 && req_byte <= 8'h39) ||
                   req_byte == xcef_pkg::ChColon) begin
         push_beat.cls = xcef_pkg::CLS_NAMECH;
      end else begin
         push_beat.cls = xcef_pkg::CLS_OTHER;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/xcef_queue.sv -----
`default_nettype none

module xcef_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  xcef_pkg::beat_type      push_beat,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output xcef_pkg::beat_type      head_beat
);

   xcef_pkg::beat_type                   slot_ff [xcef_pkg::QueueDepth];
   logic [xcef_pkg::QueuePtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [xcef_pkg::QueuePtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [xcef_pkg::QueueCntW-1:0]       cnt_ff, cnt_in;
   logic                                 do_push, do_pop;

   assign full       = (cnt_ff == xcef_pkg::QueueCntW'(xcef_pkg::QueueDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_beat  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/xcef_back.sv -----
`default_nettype none

module xcef_back #(
   parameter int unsigned MAX_DEPTH = xcef_pkg::MaxDepthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [xcef_pkg::PosW-1:0]  start_offset,
   input  wire logic                       head_valid,
   input  xcef_pkg::beat_type              head_beat,
   output logic                            pop,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output xcef_pkg::outcome_type           out_outcome,
   output logic [xcef_pkg::PosW-1:0]       out_position
);

   localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
   localparam logic [DepthW-1:0] MaxDepthW = DepthW'(MAX_DEPTH);

   xcef_pkg::phase_type              phase_ff, phase_in;
   logic [DepthW-1:0]                depth_ff, depth_in;
   logic                             name_ok_ff, name_ok_in;
   logic                             slash_ff, slash_in;
   logic [xcef_pkg::PosW-1:0]        count_ff, count_in;
   logic                             finished_ff, finished_in;
   logic                             out_valid_ff, out_valid_in;
   xcef_pkg::outcome_type            out_outcome_ff, out_outcome_in;
   logic [xcef_pkg::PosW-1:0]        out_pos_ff, out_pos_in;
   logic                             found, overflow, open_tag;
   xcef_pkg::char_class_type         cls;

   assign cls          = head_beat.cls;
   assign pop          = head_valid && (!out_valid_ff || out_ready);
   assign out_valid    = out_valid_ff;
   assign out_outcome  = out_outcome_ff;
   assign out_position = out_pos_ff;

   // Scanner step for the beat at the head of the queue, and the result register.
   always_comb begin
      phase_in       = phase_ff;
      depth_in       = depth_ff;
      name_ok_in     = name_ok_ff;
      slash_in       = slash_ff;
      count_in       = count_ff;
      finished_in    = finished_ff;
      found          = 1'b0;
      open_tag       = 1'b0;
      overflow       = 1'b0;
      out_valid_in   = out_valid_ff && !out_ready;
      out_outcome_in = out_outcome_ff;
      out_pos_in     = out_pos_ff;

      if (pop) begin
         if (!finished_ff) begin
            unique case (phase_ff)
               xcef_pkg::PH_CONTENT: begin
                  if (cls == xcef_pkg::CLS_LT) begin
                     phase_in = xcef_pkg::PH_AFTER_LT;
                  end
               end
               xcef_pkg::PH_AFTER_LT: begin
                  priority if (cls == xcef_pkg::CLS_SLASH) begin
                     if (depth_ff == '0) begin
                        found = 1'b1;
                     end else begin
                        depth_in = depth_ff - 1'b1;
                        phase_in = xcef_pkg::PH_SKIP_CLOSE;
                     end
                  end else if (cls == xcef_pkg::CLS_GT) begin
                     phase_in = xcef_pkg::PH_CONTENT;
                  end else if (cls == xcef_pkg::CLS_SPACE) begin
                     name_ok_in = 1'b0;
                     slash_in   = 1'b0;
                     phase_in   = xcef_pkg::PH_ATTR;
                  end else begin
                     name_ok_in = (cls == xcef_pkg::CLS_LETTER);
                     phase_in   = xcef_pkg::PH_NAME;
                  end
               end
               xcef_pkg::PH_NAME: begin
                  priority if (cls == xcef_pkg::CLS_GT) begin
                     open_tag = name_ok_ff;
                     phase_in = xcef_pkg::PH_CONTENT;
                  end else if (cls == xcef_pkg::CLS_SPACE || cls == xcef_pkg::CLS_SLASH) begin
                     slash_in = (cls == xcef_pkg::CLS_SLASH);
                     phase_in = xcef_pkg::PH_ATTR;
                  end else if (cls != xcef_pkg::CLS_LETTER && cls != xcef_pkg::CLS_NAMECH) begin
                     name_ok_in = 1'b0;
                  end
               end
               xcef_pkg::PH_ATTR: begin
                  if (cls == xcef_pkg::CLS_GT) begin
                     open_tag = name_ok_ff && !slash_ff;
                     phase_in = xcef_pkg::PH_CONTENT;
                  end else begin
                     slash_in = (cls == xcef_pkg::CLS_SLASH);
                  end
               end
               default: begin
                  // Skipping the rest of a closing tag.
                  if (cls == xcef_pkg::CLS_GT) begin
                     phase_in = xcef_pkg::PH_CONTENT;
                  end
               end
            endcase

            // A valid opening tag either deepens the nesting or overflows.
            if (open_tag) begin
               if (depth_ff >= MaxDepthW) begin
                  overflow = 1'b1;
               end else begin
                  depth_in = depth_ff + 1'b1;
               end
            end

            priority if (found) begin
               out_valid_in   = 1'b1;
               out_outcome_in = xcef_pkg::OUT_FOUND;
               out_pos_in     = start_offset + count_ff - 1'b1;
               finished_in    = 1'b1;
            end else if (overflow) begin
               out_valid_in   = 1'b1;
               out_outcome_in = xcef_pkg::OUT_OVERFLOW;
               out_pos_in     = '0;
               finished_in    = 1'b1;
            end else if (head_beat.eot) begin
               out_valid_in   = 1'b1;
               out_outcome_in = xcef_pkg::OUT_NOT_FOUND;
               out_pos_in     = '0;
               finished_in    = 1'b1;
            end else begin
               finished_in = finished_ff;
            end
         end

         count_in = count_ff + 1'b1;

         // The last beat of a text re-arms the scanner.
         if (head_beat.eot) begin
            phase_in    = xcef_pkg::PH_CONTENT;
            depth_in    = '0;
            name_ok_in  = 1'b0;
            slash_in    = 1'b0;
            count_in    = '0;
            finished_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= xcef_pkg::PH_CONTENT;
         depth_ff     <= '0;
         name_ok_ff   <= 1'b0;
         slash_ff     <= 1'b0;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         name_ok_ff   <= name_ok_in;
         slash_ff     <= slash_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload holds no reset.
   always_ff @(posedge clock) begin
      out_outcome_ff <= out_outcome_in;
      out_pos_ff     <= out_pos_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/xcef_checker.sv -----
`default_nettype none
`include "xml_content_end_finder_defines.svh"

module xcef_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [39:0]  rsp_tdata
);

   // A stalled result beat keeps its valid and payload.
   `XCEF_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "result beat changed while stalled")

   // Only the three defined outcome codes appear.
   `XCEF_ASSERT(a_outcome_code, clock, reset,
      rsp_tvalid |-> rsp_tdata[1:0] == xcef_pkg::OUT_FOUND ||
         rsp_tdata[1:0] == xcef_pkg::OUT_NOT_FOUND ||
         rsp_tdata[1:0] == xcef_pkg::OUT_OVERFLOW,
      "undefined outcome code")

   // A position is reported only with a found outcome.
   `XCEF_ASSERT(a_pos_zero, clock, reset,
      rsp_tvalid && rsp_tdata[1:0] != xcef_pkg::OUT_FOUND |-> rsp_tdata[33:2] == 32'd0,
      "position given without a found outcome")

   // Padding bits stay zero.
   `XCEF_ASSERT(a_pad_zero, clock, reset,
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0,
      "padding bits set")

   // Reset leaves no result beat pending.
   `XCEF_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> !rsp_tvalid,
      "result beat pending after reset")

endmodule

bind xml_content_end_finder xcef_checker u_xcef_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- sim/xml_content_end_checker.sv -----
`default_nettype none

module xml_content_end_checker #(
   parameter int unsigned MAX_DEPTH = xcef_pkg::MaxDepthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tlast,   // end_of_text
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [1:0] outcome, [33:2] end_position, rest zero
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata,
   output int unsigned      failures,
   output int unsigned      awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import xcef_pkg::*;

   // One predicted result beat.
   typedef struct packed {
      outcome_type outcome;
      logic [31:0] position;
   } content_end_type;

   content_end_type expected_ends[$];

   // Running totals handed to the top.
   int unsigned fail_count = 0;
   int unsigned pending    = 0;

   // Shadow copy of the offset register and of the scanner state.
   logic [31:0] start_offset;
   phase_type   scan_phase;
   logic [7:0]  nest_depth;
   logic        name_ok;
   logic        prev_was_slash;
   logic [31:0] byte_count;
   logic        finished;

   assign failures = fail_count;
   assign awaiting = pending;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_name_tail(input logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9") || c == ChColon;
   endfunction

   // Returns the scan state to its idle value; the offset register is kept.
   function automatic void clear_scan();
      scan_phase     = PH_CONTENT;
      nest_depth     = 8'd0;
      name_ok        = 1'b0;
      prev_was_slash = 1'b0;
      byte_count     = 32'd0;
      finished       = 1'b0;
   endfunction

   // Raises the nesting depth, or reports that the limit would be passed.
   function automatic logic open_element();
      if (nest_depth >= MAX_DEPTH) begin
         return 1'b1;
      end
      nest_depth = nest_depth + 8'd1;
      return 1'b0;
   endfunction

   // Moves the scanner on by one text byte and queues the result that it causes.
   task automatic advance_scan(input logic [7:0] c, input logic eot);
      logic            found;
      logic            overflow;
      logic            emit;
      content_end_type fresh;
      found    = 1'b0;
      overflow = 1'b0;
      emit     = 1'b0;
      fresh    = '0;
      if (!finished) begin
         case (scan_phase)
            PH_CONTENT: begin
               if (c == ChLt) begin
                  scan_phase = PH_AFTER_LT;
               end
            end
            PH_AFTER_LT: begin
               if (c == ChSlash) begin
                  if (nest_depth == 8'd0) begin
                     found = 1'b1;
                  end else begin
                     nest_depth = nest_depth - 8'd1;
                     scan_phase = PH_SKIP_CLOSE;
                  end
               end else if (c == ChGt) begin
                  scan_phase = PH_CONTENT;
               end else if (c == ChSpace) begin
                  name_ok        = 1'b0;
                  prev_was_slash = 1'b0;
                  scan_phase     = PH_ATTR;
               end else begin
                  name_ok    = is_letter(c);
                  scan_phase = PH_NAME;
               end
            end
            PH_NAME: begin
               if (c == ChGt) begin
                  if (name_ok) begin
                     overflow = open_element();
                  end
                  scan_phase = PH_CONTENT;
               end else if (c == ChSpace || c == ChSlash) begin
                  prev_was_slash = (c == ChSlash);
                  scan_phase     = PH_ATTR;
               end else if (!is_name_tail(c)) begin
                  name_ok = 1'b0;
               end
            end
            PH_ATTR: begin
               if (c == ChGt) begin
                  if (!prev_was_slash && name_ok) begin
                     overflow = open_element();
                  end
                  scan_phase = PH_CONTENT;
               end else begin
                  prev_was_slash = (c == ChSlash);
               end
            end
            default: begin
               // Inside a closing tag below the top level: skip up to its '>'.
               if (c == ChGt) begin
                  scan_phase = PH_CONTENT;
               end
            end
         endcase

         // The '<' sits one byte before the '/' that completed the match.
         if (found) begin
            fresh.outcome  = OUT_FOUND;
            fresh.position = start_offset + byte_count - 32'd1;
            emit           = 1'b1;
         end else if (overflow) begin
            fresh.outcome = OUT_OVERFLOW;
            emit          = 1'b1;
         end else if (eot) begin
            fresh.outcome = OUT_NOT_FOUND;
            emit          = 1'b1;
         end
         if (emit) begin
            expected_ends.insert(expected_ends.size(), fresh);
            finished = 1'b1;
         end
      end

      byte_count = byte_count + 32'd1;
      if (eot) begin
         clear_scan();
      end
   endtask

   // Result beats are checked before the input beat of the same edge is predicted.
   always @(posedge clock) begin
      content_end_type oldest;
      if (reset) begin
         expected_ends.delete();
         start_offset = 32'd0;
         clear_scan();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_ends.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               oldest = expected_ends.pop_front();
               if (rsp_tdata[1:0] !== oldest.outcome) begin
                  $display("%0t: outcome mismatch, expected %0d, actual %0d",
                           $time, oldest.outcome, rsp_tdata[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[33:2] !== oldest.position) begin
                  $display("%0t: end_position mismatch, expected %h, actual %h",
                           $time, oldest.position, rsp_tdata[33:2]);
                  fail_count++;
               end
               if (rsp_tdata[39:34] !== 6'd0) begin
                  $display("%0t: padding mismatch, expected %h, actual %h",
                           $time, 6'd0, rsp_tdata[39:34]);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            start_offset = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            advance_scan(req_tdata, req_tlast);
         end
      end
      pending = expected_ends.size();
   end

endmodule

`default_nettype wire

// ----- sim/tb_xml_content_end_finder.sv -----
`default_nettype none

module tb_xml_content_end_finder;
   timeunit 1ns;
   timeprecision 1ps;

   import xcef_pkg::*;

   localparam int unsigned MaxDepth     = MaxDepthDefault;
   localparam int unsigned RandomBeats  = 1700;
   localparam int unsigned PhaseBeats   = 250;
   localparam int unsigned SettleCycles = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [31:0] csr_wdata  = 32'd0;

   int unsigned failures;
   int unsigned awaiting;

   // While set, neither side of the block idles.
   logic        calm = 1'b0;

   // Text being assembled for the next run of beats.
   logic [7:0]  text_q[$];
   int unsigned beats_sent = 0;

   xml_content_end_finder #(
      .MAX_DEPTH(MaxDepth)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   xml_content_end_checker #(
      .MAX_DEPTH(MaxDepth)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .failures(failures),
      .awaiting(awaiting)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The result side stalls about a third of the time unless the run is calm.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 33);
   end

   // Offers one beat, with random idle cycles ahead of it, and waits for its acceptance.
   task automatic send_beat(input logic [7:0] c, input logic eot);
      if (!calm) begin
         while ($urandom_range(99) < 33) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      beats_sent++;
   endtask

   // Sends the assembled text, marking its final byte.
   task automatic send_text();
      foreach (text_q[i]) begin
         send_beat(text_q[i], i == text_q.size() - 1);
      end
   endtask

   // Holds the sender until every expected result has arrived, then lets the block settle.
   task automatic wait_idle(input int unsigned settle);
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (awaiting != 0);
      @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_offset(input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Adds one byte at the end of the text being assembled.
   task automatic add_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] random_name_char();
      case ($urandom_range(3))
         0, 1:    return random_letter();
         2:       return 8'h30 + 8'($urandom_range(9));
         default: return ChColon;
      endcase
   endfunction

   // A byte that spoils a tag name without ending it; a digit spoils only the first byte.
   function automatic logic [7:0] bad_name_char(input logic allow_digit);
      string spoilers;
      spoilers = "-._!?=#'";
      case ($urandom_range(allow_digit ? 2 : 1))
         0:       return spoilers[$urandom_range(spoilers.len() - 1)];
         1:       return 8'h80 + 8'($urandom_range(127));
         default: return 8'h30 + 8'($urandom_range(9));
      endcase
   endfunction

   // Noise leans on the characters that move the scanner.
   function automatic logic [7:0] noise_byte();
      string specials;
      specials = "<>/ a:1";
      if ($urandom_range(1)) begin
         return 8'($urandom_range(255));
      end
      return specials[$urandom_range(specials.len() - 1)];
   endfunction

   // Appends a tag name; an invalid one carries one spoiling byte somewhere.
   task automatic push_name(input logic valid);
      int len;
      int bad_at;
      len    = $urandom_range(4, 1);
      bad_at = valid ? -1 : int'($urandom_range(len - 1));
      for (int i = 0; i < len; i++) begin
         if (i == bad_at) begin
            add_byte(bad_name_char(i == 0));
         end else if (i == 0) begin
            add_byte(random_letter());
         end else begin
            add_byte(random_name_char());
         end
      end
   endtask

   // Appends a few quoted attributes; now and then a value holds a '>'.
   task automatic push_attrs();
      repeat ($urandom_range(2)) begin
         push_text(" k='");
         repeat ($urandom_range(3)) begin
            add_byte(($urandom_range(7) == 0) ? ChGt : random_name_char());
         end
         push_text("'");
      end
   endtask

   // Builds a text of nested elements; a whole one ends with a closing tag at the top.
   task automatic compose_markup(input logic whole);
      int   open_count;
      logic ok;
      logic [7:0] c;
      text_q.delete();
      open_count = 0;
      repeat ($urandom_range(10, 1)) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               ok = ($urandom_range(7) != 0);
               add_byte(ChLt);
               push_name(ok);
               push_attrs();
               add_byte(ChGt);
               if (ok) begin
                  open_count++;
               end
            end
            3, 4: begin
               if (open_count > 0) begin
                  push_text("</");
                  push_name(1'b1);
                  if ($urandom_range(1)) begin
                     push_text(" ");
                  end
                  add_byte(ChGt);
                  open_count--;
               end
            end
            5: begin
               // Self-closing element.
               add_byte(ChLt);
               push_name(1'b1);
               push_attrs();
               push_text($urandom_range(1) ? " />" : "/>");
            end
            6: begin
               case ($urandom_range(3))
                  0:       push_text("<>");
                  1:       push_text("< a>");
                  2:       push_text("<a/ >");
                  default: push_text("<b / >");
               endcase
            end
            default: begin
               // Plain content, mostly printable and free of '<'.
               repeat ($urandom_range(6, 1)) begin
                  c = 8'($urandom_range(126, 32));
                  if (c == ChLt) begin
                     c = ".";
                  end
                  if ($urandom_range(15) == 0) begin
                     c = 8'h80 + 8'($urandom_range(127));
                  end
                  add_byte(c);
               end
            end
         endcase
      end
      if (whole) begin
         repeat (open_count) push_text("</a>");
         push_text("</");
         repeat ($urandom_range(3)) add_byte(noise_byte());
      end
      if (text_q.size() == 0) begin
         add_byte(noise_byte());
      end
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int unsigned random_start;
      int unsigned phase_start;
      int unsigned phase;
      int unsigned pick;
      logic [31:0] offset;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed texts at the reset offset: extreme bytes before a top-level close.
      text_q.delete();
      add_byte(8'h00);
      add_byte(8'hFF);
      push_text("</");
      send_text();

      // Nested element with a colon and digit in its name, a self-closing one,
      // then the closing tag at the top level followed by a byte that gives nothing.
      text_q.delete();
      push_text("<A:9><b/></A></q");
      send_text();

      // Space before the name, a digit first, an empty name, a non-ASCII name,
      // and a lone '<' on the final byte.
      text_q.delete();
      push_text("< x><1><>");
      add_byte(ChLt);
      add_byte(8'hC1);
      add_byte(ChGt);
      push_text("<");
      send_text();

      // The reported position wraps past the top of the address range.
      wait_idle(SettleCycles);
      write_offset(32'hFFFF_FFFE);
      text_q.delete();
      push_text("ab</");
      send_text();

      random_start = beats_sent;
      phase        = 0;
      while (beats_sent - random_start < RandomBeats) begin
         wait_idle(SettleCycles);
         case (phase % 5)
            1:       offset = 32'd0;
            2:       offset = 32'hFFFF_FFFF;
            4:       offset = 32'hFFFF_FF00 | 32'($urandom_range(255));
            default: offset = $urandom;
         endcase
         write_offset(offset);
         calm        <= (phase == 2);
         phase_start = beats_sent;

         // Nesting beyond the limit, once.
         if (phase == 1) begin
            text_q.delete();
            repeat (MaxDepth + 1) push_text("<a>");
            push_text("</a></");
            send_text();
         end

         do begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               compose_markup(1'b1);
            end else if (pick < 85) begin
               compose_markup(1'b0);
            end else begin
               text_q.delete();
               repeat ($urandom_range(16, 1)) add_byte(noise_byte());
            end
            send_text();
            if ($urandom_range(24) == 0) begin
               wait_idle(0);
            end
         end while (beats_sent - phase_start < PhaseBeats);
         phase++;
      end

      wait_idle(SettleCycles);
      @(negedge clock);
      if (failures == 0 && awaiting == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
